// ===== rtl/vpg_pkg.sv =====
// Shared constants and types of the vortex pixel generator.
`default_nettype none

package vpg_pkg;

    // Matrix geometry
    localparam int MATRIX_WIDTH  = 48;
    localparam int MATRIX_HEIGHT = 16;
    localparam int HALF_W        = MATRIX_WIDTH / 2;
    localparam int HALF_H        = MATRIX_HEIGHT / 2;

    // Speed register and phase divisor
    localparam int SPEED_W     = 10;
    localparam int SPEED_RESET = 100;
    localparam int SPEED_MIN   = 10;
    localparam int SPEED_MAX   = 300;
    localparam int RATIO_NUM   = 400;
    localparam int MAX_RATIO   = RATIO_NUM / SPEED_MIN;
    localparam int DIVR_W      = $clog2(MAX_RATIO + 2);

    // Divider pipeline: phase quotient one bit a step, frac quotient likewise
    localparam int PH_W        = 32;
    localparam int DIV_STAGES  = 8;
    localparam int PH_STEPS    = PH_W / DIV_STAGES;
    localparam int FR_STEPS    = 2;
    localparam int FR_NUM_W    = FR_STEPS * DIV_STAGES;

    // Pattern constants
    localparam int FRAC_SCALE  = 63;
    localparam int V_BASE      = 120;
    localparam int SEC_W       = 43;

    // Quadrant about the center; angle base is code * 64
    typedef enum logic [1:0] {
        QUAD_UR = 2'd0,   // dx >= 0, dy < 0
        QUAD_LR = 2'd1,   // dx >= 0, dy >= 0
        QUAD_LL = 2'd2,   // dx < 0,  dy >= 0
        QUAD_UL = 2'd3    // dx < 0,  dy < 0
    } t_quad;

    // One item in flight through the divider stages
    typedef struct packed {
        logic [PH_W-1:0]     pn;    // phase dividend bits still to shift in
        logic [DIVR_W-1:0]   pr;    // phase partial remainder
        logic [8:0]          pq;    // low bits of phase quotient
        logic [DIVR_W-1:0]   pd;    // phase divisor
        logic [FR_NUM_W-1:0] fn;    // frac dividend bits still to shift in
        logic [8:0]          fr;    // frac partial remainder
        logic [5:0]          fq;    // frac quotient
        logic [8:0]          fd;    // frac divisor
        t_quad               quad;
        logic [8:0]          mdist; // Manhattan distance
    } t_div_item;

    // Divider results handed to the color stages
    typedef struct packed {
        logic [8:0] ph;
        logic [5:0] frac;
        t_quad      quad;
        logic [8:0] mdist;
    } t_geo;

endpackage

`default_nettype wire

// ===== rtl/vortex_pixel_generator.sv =====
// Top level of the vortex pixel generator.
//
// Streams one pixel per cycle. The slave channel carries the pixel column,
// row and the frame phase counter; the master channel returns the pixel's
// red, green and blue. Every transfer in gives exactly one transfer out,
// in order.
// Throughput: one pixel per cycle while the receiver keeps tready high.
// The pipeline has 13 register stages: an input stage with the center
// offsets, eight stages of the two restoring dividers (four phase quotient
// bits and two angle quotient bits each), four stages of hue, sector,
// products and channel select, the last being the output register.
// Speed: i_cfg_we writes the speed; the divisor it selects is held in a
// register and used by items accepted after the write.
// Reset clears all valid bits and sets the speed to 100 percent.
// When the receiver holds tready low with a result waiting, the whole
// pipeline holds and o_s_tready drops; nothing is lost or repeated.
`default_nettype none

module vortex_pixel_generator
    import vpg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [SPEED_W-1:0] i_cfg_data,  // speed_percent
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [47:0]        i_s_tdata,   // pixel_x, pixel_y, frame_phase
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic      [23:0]        o_m_tdata    // red, green, blue
);

    logic              w_en;
    logic [DIVR_W-1:0] w_div;
    logic              w_geo_vld;
    t_geo              w_geo;
    logic [7:0]        w_red, w_green, w_blue;

    // Pipeline advances when the output register is empty or being drained
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    vpg_speed_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_div      (w_div)
    );

    // Input stage: offsets from the center, quadrant, distance, divider setup
    logic            [7:0]  n_px, n_py, n_adx, n_ady;
    logic signed     [9:0]  n_dx, n_dy;
    logic            [8:0]  n_dist;
    logic            [13:0] n_num;
    t_div_item              n_s1;
    logic                   r_s1_vld;
    t_div_item              r_s1;

    always_comb begin
        n_px   = i_s_tdata[7:0];
        n_py   = i_s_tdata[15:8];
        n_dx   = $signed({2'b00, n_px}) - $signed(10'(HALF_W));
        n_dy   = $signed({2'b00, n_py}) - $signed(10'(HALF_H));
        n_adx  = n_dx[9] ? 8'(-n_dx) : n_dx[7:0];
        n_ady  = n_dy[9] ? 8'(-n_dy) : n_dy[7:0];
        n_dist = {1'b0, n_adx} + {1'b0, n_ady};
        n_num  = 14'({n_ady, 6'b0}) - 14'(n_ady);

        n_s1.pn    = i_s_tdata[47:16];
        n_s1.pr    = '0;
        n_s1.pq    = '0;
        n_s1.pd    = w_div;
        n_s1.fn    = FR_NUM_W'(n_num);
        n_s1.fr    = '0;
        n_s1.fq    = '0;
        n_s1.fd    = n_dist + 9'd1;
        n_s1.mdist = n_dist;
        if (!n_dx[9])
            n_s1.quad = n_dy[9] ? QUAD_UR : QUAD_LR;
        else
            n_s1.quad = n_dy[9] ? QUAD_UL : QUAD_LL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    vpg_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s1_vld),
        .i_item  (r_s1),
        .o_vld   (w_geo_vld),
        .o_geo   (w_geo)
    );

    vpg_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_geo_vld),
        .i_geo   (w_geo),
        .o_vld   (o_m_tvalid),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign o_m_tdata = {w_blue, w_green, w_red};

endmodule

`default_nettype wire

// ===== rtl/vpg_speed_cfg.sv =====
// Speed register: clamps the written speed and keeps the phase divisor.
`default_nettype none

module vpg_speed_cfg
    import vpg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [SPEED_W-1:0] i_cfg_data,
    output logic      [DIVR_W-1:0]  o_div
);

    // divisor = 400 / clamp(speed) + 1; the ratio is the count of k with k*sp <= 400
    function automatic logic [DIVR_W-1:0] div_of(logic [SPEED_W-1:0] s);
        logic [8:0]           sp;
        logic [MAX_RATIO-1:0] hit;
        sp = s[8:0];
        if (s < SPEED_W'(SPEED_MIN))
            sp = 9'(SPEED_MIN);
        else if (s > SPEED_W'(SPEED_MAX))
            sp = 9'(SPEED_MAX);
        for (int k = 1; k <= MAX_RATIO; k++)
            hit[k-1] = (16'(sp) * 16'(k)) <= 16'(RATIO_NUM);
        return DIVR_W'($countones(hit)) + DIVR_W'(1);
    endfunction

    logic [DIVR_W-1:0] r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= div_of(SPEED_W'(SPEED_RESET));
        end else if (i_cfg_we) begin
            r_div <= div_of(i_cfg_data);
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

// ===== rtl/vpg_div_pipe.sv =====
// Pipelined restoring dividers: slowed phase and in-quadrant angle term.
`default_nettype none

module vpg_div_pipe
    import vpg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_vld,
    input  wire t_div_item i_item,
    output logic           o_vld,
    output t_geo           o_geo
);

    // Four phase quotient bits and two angle quotient bits per stage
    function automatic t_div_item step(t_div_item a);
        t_div_item         b;
        logic [DIVR_W:0]   pt;
        logic [9:0]        ft;
        b = a;
        for (int i = 0; i < PH_STEPS; i++) begin
            pt   = {b.pr, b.pn[PH_W-1]};
            b.pn = {b.pn[PH_W-2:0], 1'b0};
            if (pt >= {1'b0, b.pd}) begin
                b.pr = DIVR_W'(pt - {1'b0, b.pd});
                b.pq = {b.pq[7:0], 1'b1};
            end else begin
                b.pr = pt[DIVR_W-1:0];
                b.pq = {b.pq[7:0], 1'b0};
            end
        end
        for (int i = 0; i < FR_STEPS; i++) begin
            ft   = {b.fr, b.fn[FR_NUM_W-1]};
            b.fn = {b.fn[FR_NUM_W-2:0], 1'b0};
            if (ft >= {1'b0, b.fd}) begin
                b.fr = 9'(ft - {1'b0, b.fd});
                b.fq = {b.fq[4:0], 1'b1};
            end else begin
                b.fr = ft[8:0];
                b.fq = {b.fq[4:0], 1'b0};
            end
        end
        return b;
    endfunction

    logic                      r_vld [DIV_STAGES];
    t_div_item                 r_stg [DIV_STAGES];
    t_div_item                 n_stg [DIV_STAGES];

    // Next value of every stage
    always_comb begin
        n_stg[0] = step(i_item);
        for (int s = 1; s < DIV_STAGES; s++)
            n_stg[s] = step(r_stg[s-1]);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++)
                r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < DIV_STAGES; s++)
                r_vld[s] <= r_vld[s-1];
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++)
                r_stg[s] <= n_stg[s];
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_geo = {r_stg[DIV_STAGES-1].pq, r_stg[DIV_STAGES-1].fq,
                    r_stg[DIV_STAGES-1].quad, r_stg[DIV_STAGES-1].mdist};

endmodule

`default_nettype wire

// ===== rtl/vpg_color.sv =====
// Hue and brightness forming, HSV to RGB conversion and output register.
`default_nettype none

module vpg_color
    import vpg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_vld,
    input  wire t_geo       i_geo,
    output logic            o_vld,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);

    // Hue sector, 43 hue steps each but the last, which covers 41
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    // x / 255, exact for x below 65280
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // Stage A: hue and brightness
    logic       r_a_vld;
    logic [7:0] r_a_hue, r_a_v;
    logic [7:0] n_a_hue, n_a_v, n_a_tri, n_a_angle;
    logic [8:0] n_a_w, n_a_d18;

    always_comb begin
        n_a_angle = {i_geo.quad, 6'b0} + {2'b00, i_geo.frac};
        n_a_hue   = n_a_angle + i_geo.ph[7:0];
        n_a_d18   = 9'({i_geo.mdist, 4'b0} + {3'b000, i_geo.mdist, 1'b0});
        n_a_w     = i_geo.ph + n_a_d18;
        n_a_tri   = n_a_w[8] ? ~n_a_w[7:0] : n_a_w[7:0];
        n_a_v     = 8'(V_BASE) + {1'b0, n_a_tri[7:1]};
    end

    // Stage B: sector and scaled remainder
    logic       r_b_vld;
    t_sector    r_b_sec;
    logic [7:0] r_b_rem, r_b_v;
    t_sector    n_b_sec;
    logic [7:0] n_b_off, n_b_rem;
    logic [5:0] n_b_diff;

    always_comb begin
        if (r_a_hue < 8'(SEC_W))
            n_b_sec = SEC_RY;
        else if (r_a_hue < 8'(2 * SEC_W))
            n_b_sec = SEC_YG;
        else if (r_a_hue < 8'(3 * SEC_W))
            n_b_sec = SEC_GC;
        else if (r_a_hue < 8'(4 * SEC_W))
            n_b_sec = SEC_CB;
        else if (r_a_hue < 8'(5 * SEC_W))
            n_b_sec = SEC_BM;
        else
            n_b_sec = SEC_MR;
        unique case (n_b_sec)
            SEC_RY:  n_b_off = 8'd0;
            SEC_YG:  n_b_off = 8'(SEC_W);
            SEC_GC:  n_b_off = 8'(2 * SEC_W);
            SEC_CB:  n_b_off = 8'(3 * SEC_W);
            SEC_BM:  n_b_off = 8'(4 * SEC_W);
            default: n_b_off = 8'(5 * SEC_W);
        endcase
        n_b_diff = 6'(r_a_hue - n_b_off);
        n_b_rem  = 8'({n_b_diff, 2'b0} + {1'b0, n_b_diff, 1'b0});
    end

    // Stage C: products for the falling and rising channels
    logic        r_c_vld;
    t_sector     r_c_sec;
    logic [7:0]  r_c_v;
    logic [15:0] r_c_pq, r_c_pt;

    // Stage D: channel select into the output register
    logic        r_d_vld;
    logic [7:0]  r_d_red, r_d_green, r_d_blue;
    logic [7:0]  n_q, n_t;
    logic [7:0]  n_red, n_green, n_blue;

    always_comb begin
        n_q = div255(r_c_pq);
        n_t = div255(r_c_pt);
        unique case (r_c_sec)
            SEC_RY:  begin n_red = r_c_v; n_green = n_t;   n_blue = 8'd0;  end
            SEC_YG:  begin n_red = n_q;   n_green = r_c_v; n_blue = 8'd0;  end
            SEC_GC:  begin n_red = 8'd0;  n_green = r_c_v; n_blue = n_t;   end
            SEC_CB:  begin n_red = 8'd0;  n_green = n_q;   n_blue = r_c_v; end
            SEC_BM:  begin n_red = n_t;   n_green = 8'd0;  n_blue = r_c_v; end
            default: begin n_red = r_c_v; n_green = 8'd0;  n_blue = n_q;   end
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_hue   <= n_a_hue;
            r_a_v     <= n_a_v;
            r_b_sec   <= n_b_sec;
            r_b_rem   <= n_b_rem;
            r_b_v     <= r_a_v;
            r_c_sec   <= r_b_sec;
            r_c_v     <= r_b_v;
            r_c_pq    <= {8'd0, r_b_v} * {8'd0, 8'd255 - r_b_rem};
            r_c_pt    <= {8'd0, r_b_v} * {8'd0, r_b_rem};
            r_d_red   <= n_red;
            r_d_green <= n_green;
            r_d_blue  <= n_blue;
        end
    end

    assign o_vld   = r_d_vld;
    assign o_red   = r_d_red;
    assign o_green = r_d_green;
    assign o_blue  = r_d_blue;

endmodule

`default_nettype wire
